### hdl/camera_packet_deframer_core_defines.svh
// Assertion macros shared by the camera packet deframer RTL.
// No dependencies; included by the modules that carry concurrent assertions.
`ifndef CAMERA_PACKET_DEFRAMER_CORE_DEFINES_SVH
`define CAMERA_PACKET_DEFRAMER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define CPD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("camera packet deframer: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define CPD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("camera packet deframer: next-cycle check failed");

`endif

### hdl/cpd_pkg.sv
// Shared types and constants of the camera packet deframer.
// No dependencies; used by every module of the block by scoped names.
package cpd_pkg;

  // Largest packet the deframer buffers; bigger sizes are clamped to it.
  localparam int unsigned MAX_PACKET = 1024;

  // Transport and camera header constants.
  localparam logic [15:0] MAGIC_WORD  = 16'hBBAA;
  localparam logic [7:0]  CHAN_A      = 8'd7;
  localparam logic [7:0]  CHAN_B      = 8'd11;
  localparam logic [16:0] XPORT_LEN   = 17'd5;
  localparam logic [15:0] CAM_LEN     = 16'd7;
  localparam logic [10:0] MIN_CAM_PKT = 11'd12;

  // Configuration register map.
  localparam int unsigned PADDR_W = 3;
  localparam logic        REG_FRAME_SOURCE = 1'b0;

  // Request codes.
  localparam logic REQ_PACKET = 1'b0;
  localparam logic REQ_FLUSH  = 1'b1;

  // Result status codes.
  typedef enum logic [3:0] {
    ST_APPENDED  = 4'd0,
    ST_SHORT     = 4'd1,
    ST_MAGIC     = 4'd2,
    ST_CHANNEL   = 4'd3,
    ST_TRUNCATED = 4'd4,
    ST_NO_CAMHDR = 4'd5,
    ST_LENGTH    = 4'd6,
    ST_BAD_START = 4'd7,
    ST_MISMATCH  = 4'd8
  } status_t;

  // One packet descriptor or flush request.
  typedef struct packed {
    logic        req_type;
    logic [10:0] packet_size;
    logic [15:0] magic;
    logic [7:0]  channel_id;
    logic [15:0] payload_length;
    logic [7:0]  frame_tag;
    logic [7:0]  camera_number;
    logic [7:0]  flag_bits;
  } in_item_t;

  // One result.
  typedef struct packed {
    status_t     status;
    logic        frame_done;
    logic [31:0] done_frame_number;
    logic [15:0] done_source;
    logic        button_event;
    logic [9:0]  append_count;
  } out_item_t;

endpackage

### hdl/cpd_apb_regs.sv
// APB-style configuration port of the camera packet deframer.
// Depends on cpd_pkg for the register map.
module cpd_apb_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cpd_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output logic [15:0]                 frame_source
);

  logic wr_en;

  // The port never inserts wait states.
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == cpd_pkg::REG_FRAME_SOURCE);

  // Source identifier register.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_source <= '0;
    end else if (wr_en) begin
      frame_source <= pwdata[15:0];
    end
  end

  // Read back; unmapped addresses read as zero.
  always_comb begin
    prdata = '0;
    if (paddr[2] == cpd_pkg::REG_FRAME_SOURCE) begin
      prdata = {16'd0, frame_source};
    end
  end

endmodule

### hdl/cpd_frame_ctrl.sv
// Header checks and frame state of the camera packet deframer.
// Depends on cpd_pkg and on the assertion macros header.
`include "camera_packet_deframer_core_defines.svh"

module cpd_frame_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  cpd_pkg::in_item_t  item,
  input  logic [15:0]        frame_source,
  output cpd_pkg::out_item_t result
);

  // Frame state.
  logic        frame_open;
  logic        frame_open_next;
  logic [31:0] frame_counter;
  logic [31:0] frame_counter_next;
  logic [7:0]  held_tag;
  logic [7:0]  held_tag_next;
  logic [7:0]  held_camera;
  logic [7:0]  held_camera_next;
  logic [6:0]  held_flags;
  logic [6:0]  held_flags_next;

  // Decode helpers.
  logic [10:0] size_c;
  logic [6:0]  flags;
  logic [15:0] body_len;
  logic        closing;
  logic        open_eff;
  logic        bad_hdr;

  // Oversized packets count as the largest buffer the block holds.
  always_comb begin
    if ({6'd0, item.packet_size} > 17'(cpd_pkg::MAX_PACKET)) begin
      size_c = 11'(cpd_pkg::MAX_PACKET);
    end else begin
      size_c = item.packet_size;
    end
  end

  assign flags    = {item.flag_bits[7:2], item.flag_bits[0]};
  assign body_len = item.payload_length - cpd_pkg::CAM_LEN;
  assign closing  = frame_open && (held_tag != item.frame_tag);
  assign open_eff = frame_open && !closing;
  assign bad_hdr  = !((item.camera_number < 8'd2) && (flags == 7'd0));

  // Priority checks, frame close and header capture for one transaction.
  always_comb begin
    result             = '0;
    result.status      = cpd_pkg::ST_APPENDED;
    frame_open_next    = frame_open;
    frame_counter_next = frame_counter;
    held_tag_next      = held_tag;
    held_camera_next   = held_camera;
    held_flags_next    = held_flags;
    if (item.req_type == cpd_pkg::REQ_FLUSH) begin
      if (frame_open) begin
        result.frame_done        = 1'b1;
        result.done_frame_number = frame_counter;
        result.done_source       = frame_source;
        frame_counter_next       = frame_counter + 32'd1;
        frame_open_next          = 1'b0;
      end
    end else if ({6'd0, size_c} < cpd_pkg::XPORT_LEN) begin
      result.status = cpd_pkg::ST_SHORT;
    end else if (item.magic != cpd_pkg::MAGIC_WORD) begin
      result.status = cpd_pkg::ST_MAGIC;
    end else if ((item.channel_id != cpd_pkg::CHAN_A) &&
                 (item.channel_id != cpd_pkg::CHAN_B)) begin
      result.status = cpd_pkg::ST_CHANNEL;
    end else if (({1'b0, item.payload_length} + cpd_pkg::XPORT_LEN) > {6'd0, size_c}) begin
      result.status = cpd_pkg::ST_TRUNCATED;
    end else if (size_c < cpd_pkg::MIN_CAM_PKT) begin
      result.status = cpd_pkg::ST_NO_CAMHDR;
    end else if (item.payload_length < cpd_pkg::CAM_LEN) begin
      result.status = cpd_pkg::ST_LENGTH;
    end else begin
      // A new frame tag closes the open frame first.
      if (closing) begin
        result.frame_done        = 1'b1;
        result.done_frame_number = frame_counter;
        result.done_source       = frame_source;
        frame_counter_next       = frame_counter + 32'd1;
        frame_open_next          = 1'b0;
      end
      if (!open_eff) begin
        held_tag_next    = item.frame_tag;
        held_camera_next = item.camera_number;
        held_flags_next  = flags;
        if (bad_hdr) begin
          result.status = cpd_pkg::ST_BAD_START;
        end
      end else if ((held_camera != item.camera_number) || (held_flags != flags)) begin
        result.status = cpd_pkg::ST_MISMATCH;
      end
      if (result.status == cpd_pkg::ST_APPENDED) begin
        result.button_event = item.flag_bits[1];
        result.append_count = body_len[9:0];
        if (body_len != 16'd0) begin
          frame_open_next = 1'b1;
        end
      end
    end
  end

  // State registers move only when the transaction leaves for the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open    <= 1'b0;
      frame_counter <= '0;
      held_tag      <= '0;
      held_camera   <= '0;
      held_flags    <= '0;
    end else if (advance) begin
      frame_open    <= frame_open_next;
      frame_counter <= frame_counter_next;
      held_tag      <= held_tag_next;
      held_camera   <= held_camera_next;
      held_flags    <= held_flags_next;
    end
  end

  // A closed frame always bumps the frame number by one.
  `CPD_ASSERT_NEXT(a_counter_step, clk, rst, advance && result.frame_done, frame_counter == $past(frame_counter) + 32'd1)
  // Closing a frame leaves no open frame to mismatch against.
  `CPD_ASSERT_NOW(a_close_no_mismatch, clk, rst, result.frame_done, result.status != cpd_pkg::ST_MISMATCH)
  // Appended bytes and button events only come with an accepted packet.
  `CPD_ASSERT_NOW(a_append_ok, clk, rst, (result.append_count != 10'd0) || result.button_event, result.status == cpd_pkg::ST_APPENDED)

endmodule

### hdl/camera_packet_deframer_core.sv
// An accepted transaction waits in the input register; its result is loaded into the result
// register only while that register is empty or not stalled.
// Throughput: one transaction per cycle while the result channel is not stalled; the frame
// state is read and updated by the single decision stage between the input and result registers.
// Reset (synchronous, active high) empties both registers, closes the frame
// without a result, clears the frame number, held header and source identifier.
`include "camera_packet_deframer_core_defines.svh"

module camera_packet_deframer_core (
  input  logic                        clk,
  input  logic                        rst,
  // Input channel.
  input  logic                        in_valid,
  output logic                        in_stall,
  input  cpd_pkg::in_item_t           in_data,
  // Result channel.
  output logic                        out_valid,
  input  logic                        out_stall,
  output cpd_pkg::out_item_t          out_data,
  // Configuration port.
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cpd_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  logic               in_full;
  cpd_pkg::in_item_t  in_item;
  logic               advance;
  logic               accept;
  logic [15:0]        frame_source;
  cpd_pkg::out_item_t result;

  // Configuration registers.
  cpd_apb_regs u_regs (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .frame_source (frame_source)
  );

  // Decision logic and frame state.
  cpd_frame_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .item         (in_item),
    .frame_source (frame_source),
    .result       (result)
  );

  // Pipeline handshake: the input register drains whenever the result register can load.
  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !advance;
  assign accept   = in_valid && !in_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (accept) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_item <= in_data;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

  // A held transaction is kept intact until the result register frees up.
  `CPD_ASSERT_NEXT(a_hold_pending, clk, rst, in_full && !advance, in_full && $stable(in_item))
  // A stalled result stays on the port unchanged.
  `CPD_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_data))
  // The input is only stalled when both registers are occupied.
  `CPD_ASSERT_NOW(a_stall_when_full, clk, rst, in_stall, in_full && out_valid)

endmodule

### verif/tb_camera_packet_deframer_core.sv
// Self-checking testbench for the camera packet deframer core.
// Depends on cpd_pkg and camera_packet_deframer_core; a scoreboard class predicts
// every result from the accepted descriptors and compares it field by field.
`timescale 1ns / 1ps

module tb_camera_packet_deframer_core;

  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned QUIET_LIMIT    = 2000;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned ITEMS_PER_PASS = 132;
  localparam logic [cpd_pkg::PADDR_W-1:0] FRAME_SOURCE_ADDR =
    {cpd_pkg::REG_FRAME_SOURCE, 2'b00};
  localparam logic [15:0] MAGIC = cpd_pkg::MAGIC_WORD;
  localparam logic [7:0]  CH_A  = cpd_pkg::CHAN_A;
  localparam logic [7:0]  CH_B  = cpd_pkg::CHAN_B;

  // Predicts the deframer's results and checks what the block returns.
  class deframe_scoreboard;
    logic [15:0]        frame_source;
    logic               frame_open;
    logic [31:0]        frame_number;
    logic [7:0]         held_tag;
    logic [7:0]         held_camera;
    logic [6:0]         held_flags;
    cpd_pkg::out_item_t expected_results[$];
    int unsigned        failures;

    function new();
      frame_source = '0;
      frame_open   = 1'b0;
      frame_number = '0;
      held_tag     = '0;
      held_camera  = '0;
      held_flags   = '0;
      failures     = 0;
    endfunction

    function void set_source(logic [15:0] value);
      frame_source = value;
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction

    // Closing a frame reports its number and source, then advances the count.
    function void close_frame(inout cpd_pkg::out_item_t r);
      r.frame_done        = 1'b1;
      r.done_frame_number = frame_number;
      r.done_source       = frame_source;
      frame_number        = frame_number + 32'd1;
      frame_open          = 1'b0;
    endfunction

    function cpd_pkg::out_item_t predict_result(cpd_pkg::in_item_t it);
      cpd_pkg::out_item_t r;
      logic [10:0]        size;
      logic [16:0]        needed;
      logic [6:0]         flags;
      logic [15:0]        appended;
      r        = '0;
      r.status = cpd_pkg::ST_APPENDED;
      flags    = {it.flag_bits[7:2], it.flag_bits[0]};
      if (it.req_type == cpd_pkg::REQ_FLUSH) begin
        if (frame_open) close_frame(r);
        return r;
      end
      size   = (it.packet_size > cpd_pkg::MAX_PACKET) ? 11'(cpd_pkg::MAX_PACKET)
                                                      : it.packet_size;
      needed = cpd_pkg::XPORT_LEN + it.payload_length;
      // Header checks in priority order; a failing packet leaves the state alone.
      if (size < 11'(cpd_pkg::XPORT_LEN)) begin
        r.status = cpd_pkg::ST_SHORT;
        return r;
      end
      if (it.magic != cpd_pkg::MAGIC_WORD) begin
        r.status = cpd_pkg::ST_MAGIC;
        return r;
      end
      if (it.channel_id != cpd_pkg::CHAN_A && it.channel_id != cpd_pkg::CHAN_B) begin
        r.status = cpd_pkg::ST_CHANNEL;
        return r;
      end
      if (needed > 17'(size)) begin
        r.status = cpd_pkg::ST_TRUNCATED;
        return r;
      end
      if (size < cpd_pkg::MIN_CAM_PKT) begin
        r.status = cpd_pkg::ST_NO_CAMHDR;
        return r;
      end
      if (it.payload_length < cpd_pkg::CAM_LEN) begin
        r.status = cpd_pkg::ST_LENGTH;
        return r;
      end
      // A new tag closes the open frame before the header is looked at.
      if (frame_open && held_tag != it.frame_tag) close_frame(r);
      if (!frame_open) begin
        held_tag    = it.frame_tag;
        held_camera = it.camera_number;
        held_flags  = flags;
        if (!(it.camera_number < 8'd2 && flags == 7'd0)) begin
          r.status = cpd_pkg::ST_BAD_START;
          return r;
        end
      end else if (held_tag != it.frame_tag || held_camera != it.camera_number ||
                   held_flags != flags) begin
        r.status = cpd_pkg::ST_MISMATCH;
        return r;
      end
      // Only a packet that carries payload opens the frame.
      appended       = it.payload_length - cpd_pkg::CAM_LEN;
      r.button_event = it.flag_bits[1];
      r.append_count = appended[9:0];
      if (appended != 16'd0) frame_open = 1'b1;
      return r;
    endfunction

    function void note_descriptor(cpd_pkg::in_item_t it);
      expected_results.push_back(predict_result(it));
    endfunction

    function void compare_field(string field, logic [31:0] expected, logic [31:0] actual);
      if (actual !== expected) begin
        $error("%s: expected 'h%0h, actual 'h%0h", field, expected, actual);
        failures++;
      end
    endfunction

    function void check_result(cpd_pkg::out_item_t act);
      cpd_pkg::out_item_t exp;
      if (expected_results.size() == 0) begin
        $error("result with no transaction awaiting it: 'h%0h", act);
        failures++;
        return;
      end
      exp = expected_results.pop_front();
      compare_field("status", 32'(exp.status), 32'(act.status));
      compare_field("frame_done", 32'(exp.frame_done), 32'(act.frame_done));
      compare_field("done_frame_number", exp.done_frame_number, act.done_frame_number);
      compare_field("done_source", 32'(exp.done_source), 32'(act.done_source));
      compare_field("button_event", 32'(exp.button_event), 32'(act.button_event));
      compare_field("append_count", 32'(exp.append_count), 32'(act.append_count));
    endfunction
  endclass

  logic                        clk;
  logic                        rst;
  logic                        in_valid;
  logic                        in_stall;
  cpd_pkg::in_item_t           in_data;
  logic                        out_valid;
  logic                        out_stall;
  cpd_pkg::out_item_t          out_data;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [cpd_pkg::PADDR_W-1:0] paddr;
  logic [31:0]                 pwdata;
  logic [31:0]                 prdata;
  logic                        pready;

  deframe_scoreboard board;
  cpd_pkg::in_item_t descriptor_queue[$];
  int unsigned       burst_left;
  logic              hold_wanted;
  logic [7:0]        cur_tag;
  logic [7:0]        cur_camera;

  camera_packet_deframer_core dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Both channels are observed at the rising edge.
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) board.note_descriptor(in_data);
    if (!rst && out_valid && !out_stall) board.check_result(out_data);
  end

  // Ends the run if no transaction moves on either channel for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  // Result side: stalls on patterns of varying density, with one long hold-off.
  initial begin : result_sink
    int unsigned mode;
    int unsigned span;
    out_stall = 1'b0;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      if (hold_wanted) begin
        hold_wanted = 1'b0;
        out_stall   = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(4, 64);
      repeat (span) begin
        case (mode)
          0: out_stall = 1'b0;
          1: out_stall = ($urandom_range(0, 3) == 0);
          2: out_stall = 1'($urandom_range(0, 1));
          default: out_stall = ($urandom_range(0, 3) != 0);
        endcase
        @(negedge clk);
      end
    end
  end

  function automatic cpd_pkg::in_item_t descriptor(logic [10:0] size, logic [15:0] magic,
                                                   logic [7:0] chan, logic [15:0] len,
                                                   logic [7:0] tag, logic [7:0] cam,
                                                   logic [7:0] fb);
    cpd_pkg::in_item_t it;
    it.req_type       = cpd_pkg::REQ_PACKET;
    it.packet_size    = size;
    it.magic          = magic;
    it.channel_id     = chan;
    it.payload_length = len;
    it.frame_tag      = tag;
    it.camera_number  = cam;
    it.flag_bits      = fb;
    return it;
  endfunction

  // Mostly well-formed packets that keep a frame going, with noise and broken headers.
  function automatic cpd_pkg::in_item_t random_descriptor();
    cpd_pkg::in_item_t it;
    int unsigned       pick;
    int unsigned       size;
    int unsigned       usable;
    pick = $urandom_range(0, 99);
    it   = '0;
    if (pick < 20) begin
      it.packet_size    = 11'($urandom_range(0, 2047));
      it.magic          = 16'($urandom);
      it.channel_id     = 8'($urandom);
      it.payload_length = 16'($urandom);
      it.frame_tag      = 8'($urandom);
      it.camera_number  = 8'($urandom);
      it.flag_bits      = 8'($urandom);
      it.req_type       = (pick < 5) ? cpd_pkg::REQ_FLUSH : cpd_pkg::REQ_PACKET;
      return it;
    end
    if ($urandom_range(0, 99) < 15) begin
      cur_tag    = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
      cur_camera = 8'($urandom_range(0, 1));
    end
    case ($urandom_range(0, 19))
      0:       size = $urandom_range(1025, 2047);
      1, 2, 3: size = $urandom_range(300, 1024);
      default: size = $urandom_range(12, 300);
    endcase
    usable = (size > cpd_pkg::MAX_PACKET) ? cpd_pkg::MAX_PACKET : size;
    it.req_type       = cpd_pkg::REQ_PACKET;
    it.packet_size    = 11'(size);
    it.magic          = MAGIC;
    it.channel_id     = $urandom_range(0, 1) ? CH_A : CH_B;
    it.payload_length = ($urandom_range(0, 9) == 0) ? cpd_pkg::CAM_LEN
                        : 16'(7 + $urandom_range(0, usable - 12));
    it.frame_tag      = cur_tag;
    it.camera_number  = ($urandom_range(0, 9) == 0) ? 8'($urandom) : cur_camera;
    it.flag_bits      = ($urandom_range(0, 9) == 0) ? 8'($urandom)
                        : {6'd0, 1'($urandom_range(0, 1)), 1'b0};
    // Broken headers: one field spoilt in an otherwise good packet.
    if (pick < 30) begin
      case ($urandom_range(0, 3))
        0: it.magic = it.magic ^ 16'(1 << $urandom_range(0, 15));
        1: it.channel_id = 8'($urandom);
        2: it.payload_length = 16'(usable - 5 + $urandom_range(1, 40));
        default: it.packet_size = 11'($urandom_range(0, 11));
      endcase
    end
    return it;
  endfunction

  // Sends the queued descriptors in bursts of random length with random gaps.
  task automatic play_descriptors();
    cpd_pkg::in_item_t it;
    while (descriptor_queue.size() > 0) begin
      if (burst_left == 0) begin
        in_valid = 1'b0;
        if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 8)) @(negedge clk);
        burst_left = $urandom_range(1, 30);
      end
      it       = descriptor_queue.pop_front();
      in_valid = 1'b1;
      in_data  = it;
      do @(posedge clk); while (in_stall);
      @(negedge clk);
      burst_left--;
    end
    in_valid = 1'b0;
  endtask

  task automatic queue_random(int unsigned count);
    repeat (count) descriptor_queue.push_back(random_descriptor());
  endtask

  // Holds the sender back until every expected result has been returned.
  task automatic wait_for_results();
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Setup and access cycles of a configuration write.
  task automatic write_frame_source(logic [15:0] value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = FRAME_SOURCE_ADDR;
    pwdata  = {16'd0, value};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    board.set_source(value);
  endtask

  // Main sequence: reset, then four passes with different source identifiers.
  initial begin : stimulus
    cpd_pkg::in_item_t flush_req;
    logic [15:0]       source_setting[4];
    int unsigned       pass;
    board       = new();
    rst         = 1'b1;
    in_valid    = 1'b0;
    in_data     = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    burst_left  = 0;
    hold_wanted = 1'b0;
    cur_tag     = 8'd0;
    cur_camera  = 8'd0;
    flush_req          = '0;
    flush_req.req_type = cpd_pkg::REQ_FLUSH;
    source_setting[0]  = 16'hFFFF;
    source_setting[1]  = 16'h0000;
    source_setting[2]  = 16'($urandom);
    source_setting[3]  = 16'h0001;
    repeat (4) @(negedge clk);
    rst = 1'b0;

    for (pass = 0; pass < 4; pass++) begin
      wait_for_results();
      write_frame_source(source_setting[pass]);
      if (pass == 0) begin
        // Flush with nothing open, then each header check in turn.
        descriptor_queue.push_back(flush_req);
        descriptor_queue.push_back(descriptor(11'd0, MAGIC, CH_A, 16'd7, 8'd0, 8'd0, 8'd0));
        descriptor_queue.push_back(descriptor(11'd4, MAGIC, CH_A, 16'd0, 8'd0, 8'd0, 8'd0));
        descriptor_queue.push_back(descriptor(11'd100, 16'h0000, CH_A, 16'd20, 8'd0, 8'd0, 8'd0));
        descriptor_queue.push_back(descriptor(11'd100, 16'hFFFF, CH_B, 16'd20, 8'd0, 8'd0, 8'd0));
        descriptor_queue.push_back(descriptor(11'd100, MAGIC, 8'd0, 16'd20, 8'd0, 8'd0, 8'd0));
        descriptor_queue.push_back(descriptor(11'd100, MAGIC, 8'd255, 16'd20, 8'd0, 8'd0, 8'd0));
        descriptor_queue.push_back(descriptor(11'd100, MAGIC, CH_A, 16'd96, 8'd0, 8'd0, 8'd0));
        descriptor_queue.push_back(descriptor(11'd11, MAGIC, CH_A, 16'd6, 8'd0, 8'd0, 8'd0));
        descriptor_queue.push_back(descriptor(11'd12, MAGIC, CH_B, 16'd6, 8'd0, 8'd0, 8'd0));
        // Empty payload is accepted but leaves the frame closed.
        descriptor_queue.push_back(descriptor(11'd12, MAGIC, CH_A, 16'd7, 8'd0, 8'd0, 8'd0));
        // Bad starts: camera number, other flag bits, g-sensor bit.
        descriptor_queue.push_back(descriptor(11'd40, MAGIC, CH_A, 16'd30, 8'd0, 8'd2, 8'd0));
        descriptor_queue.push_back(descriptor(11'd40, MAGIC, CH_A, 16'd30, 8'd0, 8'd1, 8'h04));
        descriptor_queue.push_back(descriptor(11'd40, MAGIC, CH_A, 16'd30, 8'd0, 8'd0, 8'h01));
        // Largest append opens a frame; a button press continues it.
        descriptor_queue.push_back(descriptor(11'd1024, MAGIC, CH_A, 16'd1019, 8'd0, 8'd1, 8'd0));
        descriptor_queue.push_back(descriptor(11'd200, MAGIC, CH_B, 16'd100, 8'd0, 8'd1, 8'h02));
        // Header mismatches against the open frame.
        descriptor_queue.push_back(descriptor(11'd200, MAGIC, CH_A, 16'd100, 8'd0, 8'd0, 8'd0));
        descriptor_queue.push_back(descriptor(11'd200, MAGIC, CH_A, 16'd100, 8'd0, 8'd1, 8'hFE));
        // Tag change closes the frame; oversized sizes are clamped.
        descriptor_queue.push_back(descriptor(11'd2047, MAGIC, CH_A, 16'd1019, 8'd255, 8'd1, 8'd0));
        descriptor_queue.push_back(descriptor(11'd1025, MAGIC, CH_A, 16'd1020, 8'd255, 8'd1, 8'd0));
        descriptor_queue.push_back(descriptor(11'd1024, MAGIC, CH_A, 16'hFFFF, 8'd255, 8'd1, 8'd0));
        // Flush closes the open frame, a second flush finds none.
        descriptor_queue.push_back(flush_req);
        descriptor_queue.push_back(flush_req);
        descriptor_queue.push_back(descriptor(11'd30, MAGIC, CH_B, 16'd20, 8'h80, 8'd255, 8'hFF));
        descriptor_queue.push_back(descriptor(11'd30, MAGIC, CH_B, 16'd20, 8'h80, 8'd0, 8'h02));
        // Tag change that closes the frame and is then a bad start.
        descriptor_queue.push_back(descriptor(11'd30, MAGIC, CH_B, 16'd20, 8'h01, 8'd5, 8'd0));
        play_descriptors();
        queue_random(ITEMS_PER_PASS);
        play_descriptors();
      end else if (pass == 1) begin
        // The sink holds off while the sender keeps offering.
        hold_wanted = 1'b1;
        queue_random(ITEMS_PER_PASS);
        play_descriptors();
      end else if (pass == 2) begin
        queue_random(ITEMS_PER_PASS / 2);
        play_descriptors();
        wait_for_results();
        queue_random(ITEMS_PER_PASS / 2);
        play_descriptors();
      end else begin
        queue_random(ITEMS_PER_PASS);
        play_descriptors();
      end
    end

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.pending() != 0) begin
      $error("results still awaited at the end: %0d", board.pending());
      board.failures++;
    end
    if (board.failures == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+hdl
hdl/cpd_pkg.sv
hdl/cpd_apb_regs.sv
hdl/cpd_frame_ctrl.sv
hdl/camera_packet_deframer_core.sv
verif/tb_camera_packet_deframer_core.sv
